[sv/cgcl_pkg.sv]
package cgcl_pkg;

  // Grid geometry; chunk sides are powers of two
  localparam int CHUNK_WIDTH   = 32;
  localparam int CHUNK_HEIGHT  = 32;
  localparam int MAX_CHUNKS    = 64;
  localparam int FRACTION_BITS = 8;

  localparam int CW_LOG = $clog2(CHUNK_WIDTH);
  localparam int CH_LOG = $clog2(CHUNK_HEIGHT);

  // Fixed field widths
  localparam int COORD_W  = 24;
  localparam int KEY_W    = 11;
  localparam int OFFSET_W = 10;
  localparam int SLOT_W   = 6;

  // Slot index and fill count widths follow the table depth
  localparam int IDX_W = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int CNT_W = $clog2(MAX_CHUNKS + 1);

  typedef logic signed [KEY_W-1:0] key_t;

  // Search token handed from cell to cell
  typedef struct packed {
    logic             vld;
    logic             hit;
    logic [IDX_W-1:0] slot;
  } tok_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_FINISH
  } state_t;

endpackage

[sv/cgcl_if.sv]
interface cgcl_in_if;
  logic                                      valid;
  logic                                      ready;
  logic                                      mode;
  logic signed [cgcl_pkg::COORD_W-1:0]       x_coord;
  logic signed [cgcl_pkg::COORD_W-1:0]       y_coord;

  modport source (output valid, mode, x_coord, y_coord, input ready);
  modport sink   (input valid, mode, x_coord, y_coord, output ready);
endinterface

interface cgcl_out_if;
  logic                                valid;
  logic                                ready;
  logic                                found;
  logic                                allocated;
  logic                                table_full;
  logic [cgcl_pkg::SLOT_W-1:0]         slot_index;
  logic [cgcl_pkg::OFFSET_W-1:0]       cell_offset;
  logic signed [cgcl_pkg::KEY_W-1:0]   chunk_col;
  logic signed [cgcl_pkg::KEY_W-1:0]   chunk_row;

  modport source (output valid, found, allocated, table_full, slot_index, cell_offset,
                  chunk_col, chunk_row, input ready);
  modport sink   (input valid, found, allocated, table_full, slot_index, cell_offset,
                  chunk_col, chunk_row, output ready);
endinterface

[sv/chunked_grid_cell_locator.sv]
// Channel   Port    Dir  Payload
// input     in_ch   in   mode, x_coord, y_coord
// result    out_ch  out  found, allocated, table_full, slot_index, cell_offset,
//                        chunk_col, chunk_row
//
// One item at a time: the next item is not accepted until the search token
// has walked the chain of table cells, one cell per cycle, and the result
// has been loaded into the output register.
// Reset (rst_n low, synchronous) empties the table by clearing the fill count;
// slot contents are not cleared.
// A result waiting in the output register does not block the next item; a
// finished search holds in its last state until that register is free.
module chunked_grid_cell_locator (
  input  logic              clk,
  input  logic              rst_n,
  cgcl_in_if.sink           in_ch,
  cgcl_out_if.source        out_ch
);

  cgcl_pkg::state_t state_r, state_nxt;

  // Item held for the search
  logic                                mode_r;
  cgcl_pkg::key_t                      key_col_r;
  cgcl_pkg::key_t                      key_row_r;
  logic [cgcl_pkg::OFFSET_W-1:0]       offset_r;
  logic                                start_r;

  // Search outcome captured from the end of the chain
  logic                                hit_r;
  logic [cgcl_pkg::IDX_W-1:0]          hit_slot_r;

  logic [cgcl_pkg::CNT_W-1:0]          count_r;

  // Output register
  logic                                out_vld_r;
  logic                                found_r, alloc_r, full_r;
  logic [cgcl_pkg::SLOT_W-1:0]         slot_out_r;
  logic [cgcl_pkg::OFFSET_W-1:0]       offset_out_r;
  cgcl_pkg::key_t                      col_out_r, row_out_r;

  // FSM outputs
  logic accept, load;

  // Coordinate split of the incoming item
  logic signed [cgcl_pkg::COORD_W-1:0] cx, cy, kx, ky;
  logic [cgcl_pkg::COORD_W-1:0]        col_w, row_w, off_w;

  // Result decisions
  logic                                has_room, res_alloc, res_full, res_found;
  logic [cgcl_pkg::IDX_W-1:0]          res_slot;

  cgcl_pkg::tok_t tok_w [cgcl_pkg::MAX_CHUNKS+1];

  // Floor by arithmetic shift; the cell column and row are the low bits
  always_comb begin
    cx    = in_ch.x_coord >>> cgcl_pkg::FRACTION_BITS;
    cy    = in_ch.y_coord >>> cgcl_pkg::FRACTION_BITS;
    kx    = cx >>> cgcl_pkg::CW_LOG;
    ky    = cy >>> cgcl_pkg::CH_LOG;
    col_w = unsigned'(cx) & cgcl_pkg::COORD_W'(cgcl_pkg::CHUNK_WIDTH - 1);
    row_w = unsigned'(cy) & cgcl_pkg::COORD_W'(cgcl_pkg::CHUNK_HEIGHT - 1);
    off_w = col_w + (row_w << cgcl_pkg::CW_LOG);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cgcl_pkg::S_IDLE:   if (in_ch.valid) state_nxt = cgcl_pkg::S_SEARCH;
      cgcl_pkg::S_SEARCH: if (tok_w[cgcl_pkg::MAX_CHUNKS].vld) state_nxt = cgcl_pkg::S_FINISH;
      cgcl_pkg::S_FINISH: if (!out_vld_r || out_ch.ready) state_nxt = cgcl_pkg::S_IDLE;
      default:            state_nxt = cgcl_pkg::S_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    in_ch.ready = 1'b0;
    load        = 1'b0;
    unique case (state_r)
      cgcl_pkg::S_IDLE:   in_ch.ready = 1'b1;
      cgcl_pkg::S_SEARCH: ;
      cgcl_pkg::S_FINISH: load = !out_vld_r || out_ch.ready;
      default:            ;
    endcase
  end

  assign accept = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cgcl_pkg::S_IDLE;
      start_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      start_r <= accept;
    end
  end

  // Hold the item's key and offset for the whole search
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r    <= in_ch.mode;
      key_col_r <= kx[cgcl_pkg::KEY_W-1:0];
      key_row_r <= ky[cgcl_pkg::KEY_W-1:0];
      offset_r  <= off_w[cgcl_pkg::OFFSET_W-1:0];
    end
  end

  // Inject a fresh token at the head of the chain
  assign tok_w[0] = '{vld: start_r, hit: 1'b0, slot: '0};

  for (genvar i = 0; i < cgcl_pkg::MAX_CHUNKS; i++) begin : g_cell
    cgcl_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (cgcl_pkg::IDX_W'(i)),
      .count    (count_r),
      .key_col  (key_col_r),
      .key_row  (key_row_r),
      .wr_en    (load && res_alloc),
      .tok_i    (tok_w[i]),
      .tok_o    (tok_w[i+1])
    );
  end

  // Capture the token as it drops off the end of the chain
  always_ff @(posedge clk) begin
    if (state_r == cgcl_pkg::S_SEARCH && tok_w[cgcl_pkg::MAX_CHUNKS].vld) begin
      hit_r      <= tok_w[cgcl_pkg::MAX_CHUNKS].hit;
      hit_slot_r <= tok_w[cgcl_pkg::MAX_CHUNKS].slot;
    end
  end

  // A miss in allocate mode appends at the fill count, or flags a full table
  always_comb begin
    has_room  = count_r < cgcl_pkg::CNT_W'(cgcl_pkg::MAX_CHUNKS);
    res_alloc = !hit_r && mode_r && has_room;
    res_full  = !hit_r && mode_r && !has_room;
    res_found = hit_r || res_alloc;
    if (hit_r) begin
      res_slot = hit_slot_r;
    end else if (res_alloc) begin
      res_slot = cgcl_pkg::IDX_W'(count_r);
    end else begin
      res_slot = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (load && res_alloc) begin
      count_r <= count_r + cgcl_pkg::CNT_W'(1);
    end
  end

  // Output register: load on finish, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (load) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      found_r      <= res_found;
      alloc_r      <= res_alloc;
      full_r       <= res_full;
      slot_out_r   <= cgcl_pkg::SLOT_W'(res_slot);
      offset_out_r <= offset_r;
      col_out_r    <= key_col_r;
      row_out_r    <= key_row_r;
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.found       = found_r;
  assign out_ch.allocated   = alloc_r;
  assign out_ch.table_full  = full_r;
  assign out_ch.slot_index  = slot_out_r;
  assign out_ch.cell_offset = offset_out_r;
  assign out_ch.chunk_col   = col_out_r;
  assign out_ch.chunk_row   = row_out_r;

  // The fill count never passes the table depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= cgcl_pkg::CNT_W'(cgcl_pkg::MAX_CHUNKS))
    else $error("fill count beyond table depth");

  // A token only leaves the chain while a search is running
  a_tok_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    tok_w[cgcl_pkg::MAX_CHUNKS].vld |-> state_r == cgcl_pkg::S_SEARCH)
    else $error("stray search token");

  // An append bumps the fill count by one
  a_alloc_count: assert property (@(posedge clk) disable iff (!rst_n)
    (load && res_alloc) |=> count_r == $past(count_r) + cgcl_pkg::CNT_W'(1))
    else $error("append did not advance fill count");

  // A full flag is only raised on a full table
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (load && res_full) |-> count_r == cgcl_pkg::CNT_W'(cgcl_pkg::MAX_CHUNKS))
    else $error("table full flagged with free slots");

  // An appended result always reports a slot
  a_alloc_found: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.allocated) |-> out_ch.found && !out_ch.table_full)
    else $error("inconsistent result flags");

endmodule

[sv/cgcl_cell.sv]
module cgcl_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [cgcl_pkg::IDX_W-1:0] cell_idx,
  input  logic [cgcl_pkg::CNT_W-1:0] count,
  input  cgcl_pkg::key_t             key_col,
  input  cgcl_pkg::key_t             key_row,
  input  logic                       wr_en,
  input  cgcl_pkg::tok_t             tok_i,
  output cgcl_pkg::tok_t             tok_o
);

  cgcl_pkg::key_t entry_col_r;
  cgcl_pkg::key_t entry_row_r;
  cgcl_pkg::tok_t tok_r;
  cgcl_pkg::tok_t tok_nxt;
  logic           in_use;
  logic           wr_here;

  assign in_use  = cgcl_pkg::CNT_W'(cell_idx) < count;
  assign wr_here = wr_en && (cgcl_pkg::CNT_W'(cell_idx) == count);

  // Claim the token on the first live match; otherwise pass it on
  always_comb begin
    tok_nxt = tok_i;
    if (tok_i.vld && !tok_i.hit && in_use &&
        entry_col_r == key_col && entry_row_r == key_row) begin
      tok_nxt.hit  = 1'b1;
      tok_nxt.slot = cell_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_here) begin
      entry_col_r <= key_col;
      entry_row_r <= key_row;
    end
  end

  assign tok_o = tok_r;

endmodule
